// ===== hdl/swm_pkg.sv =====
`default_nettype none

package swm_pkg;

   // Fixed field widths of the stream payload
   localparam int SAMPLE_PORT_W = 12;
   localparam int MEDIAN_W      = 12;
   localparam int REQ_DATA_W    = ((SAMPLE_PORT_W + 7) / 8) * 8;

   // Operation codes carried in req_tuser
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;    // take sample and valid from the left neighbour
      logic clear;   // drop the held sample
   } cell_ctrl_type;

   typedef struct packed {
      logic clear_med;  // start of an item: median reads zero until found
      logic load;       // latch the head cell as the candidate
      logic compare;    // rank the head cell against the candidate
      logic close;      // end of lap: keep the candidate if its rank fits
   } rank_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/swm_cell.sv =====
`default_nettype none

module swm_cell #(
   parameter int SW = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire swm_pkg::cell_ctrl_type ctrl,
   input  wire logic [SW-1:0]          d_in,
   input  wire logic                   v_in,
   output logic      [SW-1:0]          q,
   output logic                        v_q
);

   logic [SW-1:0] sample_ff;
   logic          valid_ff;
   logic          valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.load) begin
         valid_in = v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sample_ff <= d_in;
      end
   end

   assign q   = sample_ff;
   assign v_q = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/swm_rank.sv =====
`default_nettype none

module swm_rank #(
   parameter int SW = 12,
   parameter int CW = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire swm_pkg::rank_ctrl_type ctrl,
   input  wire logic [SW-1:0]          head,
   input  wire logic                   head_v,
   input  wire logic [CW-1:0]          target,
   output logic      [SW-1:0]          median
);

   logic [SW-1:0] cand_ff, cand_in;
   logic          cand_v_ff, cand_v_in;
   logic [CW-1:0] less_ff, less_in;
   logic [CW-1:0] equal_ff, equal_in;
   logic [SW-1:0] med_ff, med_in;
   logic [CW:0]   upper;
   logic          hit;

   // Candidate owns the pick when less <= target < less + equal
   always_comb begin
      upper = {1'b0, less_ff} + {1'b0, equal_ff};
      hit   = cand_v_ff && (less_ff <= target) && ({1'b0, target} < upper);
   end

   always_comb begin
      cand_in   = cand_ff;
      cand_v_in = cand_v_ff;
      less_in   = less_ff;
      equal_in  = equal_ff;
      med_in    = med_ff;
      if (ctrl.clear_med) begin
         med_in = '0;
      end
      if (ctrl.load) begin
         cand_in   = head;
         cand_v_in = head_v;
         less_in   = '0;
         equal_in  = '0;
      end
      if (ctrl.compare && head_v) begin
         if (head < cand_ff) begin
            less_in = less_ff + CW'(1);
         end else if (head == cand_ff) begin
            equal_in = equal_ff + CW'(1);
         end
      end
      if (ctrl.close && hit) begin
         med_in = cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_v_ff <= 1'b0;
      end else begin
         cand_v_ff <= cand_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      less_ff  <= less_in;
      equal_ff <= equal_in;
      med_ff   <= med_in;
   end

   assign median = med_ff;

endmodule

`default_nettype wire

// ===== hdl/sample_window_median.sv =====
// Running median over the last WINDOW converter samples. Each request beat either stores a
// sample (req_tuser = 0; the oldest one drops out once the window is full) or clears the
// window (req_tuser = 1), and yields exactly one response beat with the median at ascending
// rank count/2 (upper median for even counts, zero when empty), the held count and a flag
// that is set when any sample is held. Samples sit in a row of cells that shifts on a store;
// for the median the row rotates past a rank counter at its head, one lap per candidate and
// WINDOW laps per item; after the last lap the response beat is loaded once the output is free.
// One item is in work at a time; the next request is taken while the response still waits.
`default_nettype none

module sample_window_median #(
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12,
   localparam int CNT_W      = $clog2(WINDOW + 1),
   localparam int RSP_DATA_W = ((swm_pkg::MEDIAN_W + CNT_W + 7) / 8) * 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [swm_pkg::REQ_DATA_W-1:0] req_tdata,   // sample
   input  wire logic [0:0]                     req_tuser,   // operation
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [RSP_DATA_W-1:0]          rsp_tdata,   // median, valid_samples
   output logic      [0:0]                     rsp_tuser    // median_valid
);

   localparam int STORE_W = (SAMPLE_BITS < swm_pkg::SAMPLE_PORT_W) ?
                            SAMPLE_BITS : swm_pkg::SAMPLE_PORT_W;
   localparam int STEP_W  = $clog2(WINDOW + 2);

   swm_pkg::state_type     state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       lap_ff, lap_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [swm_pkg::MEDIAN_W-1:0] rsp_median_ff;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic                   rsp_flag_ff;

   logic                   accept;
   logic                   rotate;
   logic                   out_load;
   swm_pkg::cell_ctrl_type cell_ctrl;
   swm_pkg::rank_ctrl_type rank_ctrl;

   logic [STORE_W-1:0]     cell_d [WINDOW];
   logic                   cell_vd [WINDOW];
   logic [STORE_W-1:0]     cell_q [WINDOW];
   logic                   cell_v [WINDOW];
   logic [WINDOW-1:0]      valid_vec;
   logic [STORE_W-1:0]     median;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      cell_ctrl.load  = (accept && (req_tuser[0] == swm_pkg::OP_STORE)) || rotate;
      cell_ctrl.clear = accept && (req_tuser[0] == swm_pkg::OP_CLEAR);
   end

   // Cell 0 takes the new sample on a store and wraps the tail while rotating
   genvar gi;
   generate
      for (gi = 0; gi < WINDOW; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign cell_d[gi]  = rotate ? cell_q[WINDOW-1] : req_tdata[STORE_W-1:0];
            assign cell_vd[gi] = rotate ? cell_v[WINDOW-1] : 1'b1;
         end else begin : g_body
            assign cell_d[gi]  = cell_q[gi-1];
            assign cell_vd[gi] = cell_v[gi-1];
         end
         swm_cell #(
            .SW (STORE_W)
         ) u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (cell_ctrl),
            .d_in  (cell_d[gi]),
            .v_in  (cell_vd[gi]),
            .q     (cell_q[gi]),
            .v_q   (cell_v[gi])
         );
         assign valid_vec[gi] = cell_v[gi];
      end
   endgenerate

   swm_rank #(
      .SW (STORE_W),
      .CW (CNT_W)
   ) u_rank (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (rank_ctrl),
      .head   (cell_q[0]),
      .head_v (cell_v[0]),
      .target (count_ff >> 1),
      .median (median)
   );

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_tuser[0] == swm_pkg::OP_CLEAR) begin
            count_in = '0;
         end else if (count_ff < CNT_W'(WINDOW)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      lap_in     = lap_ff;
      req_tready = 1'b0;
      rotate     = 1'b0;
      out_load   = 1'b0;
      rank_ctrl  = '0;
      case (state_ff)
         swm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in            = swm_pkg::ST_SCAN;
               step_in             = '0;
               lap_in              = '0;
               rank_ctrl.clear_med = 1'b1;
            end
         end
         swm_pkg::ST_SCAN: begin
            // A lap rotates WINDOW+1 times, so the next lap starts on the next entry
            rank_ctrl.load    = (step_ff == '0);
            rank_ctrl.compare = (step_ff != '0) && (step_ff <= STEP_W'(WINDOW));
            rank_ctrl.close   = (step_ff == STEP_W'(WINDOW + 1));
            rotate            = (step_ff <= STEP_W'(WINDOW));
            if (step_ff == STEP_W'(WINDOW + 1)) begin
               step_in = '0;
               if (lap_ff == CNT_W'(WINDOW - 1)) begin
                  state_in = swm_pkg::ST_DONE;
               end else begin
                  lap_in = lap_ff + CNT_W'(1);
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         swm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swm_pkg::ST_IDLE;
         step_ff      <= '0;
         lap_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         lap_ff       <= lap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_median_ff <= swm_pkg::MEDIAN_W'(median);
         rsp_count_ff  <= count_ff;
         rsp_flag_ff   <= (count_ff != '0);
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'({rsp_count_ff, rsp_median_ff});
   assign rsp_tuser[0] = rsp_flag_ff;

   // Held samples are exactly the valid cells
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("held count differs from valid cells");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("held count above window");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == swm_pkg::ST_DONE))
      else $error("response raised outside completion");

   a_flag_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_flag_ff == (rsp_count_ff != '0)))
      else $error("median flag inconsistent with count");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swm_pkg::ST_SCAN) |=> !$past(accept))
      else $error("request taken during scan");

endmodule

`default_nettype wire
